FILE: design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// Token and result codes, stack entry layout, microcode word and the program.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int OP_W    = 3;
    localparam int REF_W   = 16;
    localparam int OKIND_W = 2;
    localparam int ARITY_W = 6;
    localparam int ERR_W   = 3;
    localparam int UPC_W   = 6;

    // Highest stored delimiter count; arity is count plus one.
    localparam logic [ARITY_W-1:0] ARG_MAX = ARITY_W'(31);

    // Operator codes: + and - are level 1, *, / and % level 2.
    localparam logic [OP_W-1:0] OP_SUB = OP_W'(1);
    localparam logic [OP_W-1:0] OP_MOD = OP_W'(4);

    // Status codes. Bad token (4) cannot occur: every token kind is defined.
    localparam logic [ERR_W-1:0] ERR_OK       = ERR_W'(0);
    localparam logic [ERR_W-1:0] ERR_BAD_OP   = ERR_W'(1);
    localparam logic [ERR_W-1:0] ERR_PARENS   = ERR_W'(2);
    localparam logic [ERR_W-1:0] ERR_DELIM    = ERR_W'(3);
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = ERR_W'(5);

    typedef enum logic [KIND_W-1:0] {
        K_NUMBER   = 3'd0,
        K_NAME     = 3'd1,
        K_OPERATOR = 3'd2,
        K_OPEN     = 3'd3,
        K_CLOSE    = 3'd4,
        K_DELIM    = 3'd5,
        K_SPACE    = 3'd6,
        K_END      = 3'd7
    } t_kind;

    typedef enum logic [OKIND_W-1:0] {
        O_OPERAND  = 2'd0,
        O_OPERATOR = 2'd1,
        O_CALL     = 2'd2,
        O_STATUS   = 2'd3
    } t_okind;

    // One operator stack entry. ctx: the innermost parenthesis at or below
    // this entry exists and is a function parenthesis.
    typedef struct packed {
        logic               paren;
        logic               func;
        logic               ctx;
        logic [OP_W-1:0]    op;
        logic [REF_W-1:0]   name_ref;
        logic [ARITY_W-1:0] argc;
    } t_entry;

    typedef struct packed {
        t_okind             kind;
        logic [REF_W-1:0]   ref_id;
        logic [OP_W-1:0]    op;
        logic [ARITY_W-1:0] arity;
        logic [ERR_W-1:0]   err;
    } t_result;

    // Result source of a step
    typedef enum logic [2:0] {
        E_NONE   = 3'd0,
        E_HELD   = 3'd1,  // held name as operand, if one is held
        E_TOK    = 3'd2,  // current token as operand
        E_TOPOP  = 3'd3,  // operator on top of stack
        E_FUNC   = 3'd4,  // function call, if top is a function paren
        E_STATUS = 3'd5,  // status with the word's error code
        E_ENDST  = 3'd6   // end status: parens open or ok
    } t_emit;

    typedef enum logic [2:0] {
        S_NONE    = 3'd0,
        S_POP     = 3'd1,
        S_LOAD    = 3'd2,  // take new top from stack memory
        S_PUSHOP  = 3'd3,
        S_PUSHPAR = 3'd4,
        S_CLEAR   = 3'd5,
        S_INCARG  = 3'd6
    } t_stk;

    typedef enum logic [1:0] {
        H_NONE = 2'd0,
        H_SET  = 2'd1,
        H_CLR  = 2'd2
    } t_held;

    typedef enum logic [2:0] {
        C_NEVER   = 3'd0,
        C_ALWAYS  = 3'd1,
        C_BADOP   = 3'd2,
        C_OP_STOP = 3'd3,  // operator pop loop must stop
        C_FULL    = 3'd4,
        C_PSTOP   = 3'd5,  // empty or paren on top
        C_EMPTY   = 3'd6,
        C_NO_CTX  = 3'd7   // no enclosing function paren
    } t_cond;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_emit            emit;
        logic [ERR_W-1:0] err;
        t_stk             stk;
        t_held            held;
        logic             lset;
        t_cond            cond;
        t_upc             target;
        logic             fin;
    } t_uword;

    typedef struct packed {
        logic   busy;
        t_uword uw;
    } t_ctrl;

    typedef struct packed {
        logic  acc;
        t_kind in_kind;
        logic  latched;
        logic  stall;
        logic  empty;
        logic  full;
        logic  top_paren;
        logic  op_stop;
        logic  no_ctx;
        logic  badop;
    } t_dpstat;

    // Program labels
    localparam t_upc L_NUM     = t_upc'(0);
    localparam t_upc L_NAME    = t_upc'(2);
    localparam t_upc L_OPR     = t_upc'(3);
    localparam t_upc L_OP_LOOP = t_upc'(4);
    localparam t_upc L_OP_PUSH = t_upc'(7);
    localparam t_upc L_OPEN    = t_upc'(9);
    localparam t_upc L_CLOSE   = t_upc'(11);
    localparam t_upc L_CL_LOOP = t_upc'(12);
    localparam t_upc L_CL_DONE = t_upc'(15);
    localparam t_upc L_DELIM   = t_upc'(18);
    localparam t_upc L_DL_LOOP = t_upc'(19);
    localparam t_upc L_DL_DONE = t_upc'(22);
    localparam t_upc L_END     = t_upc'(23);
    localparam t_upc L_EN_LOOP = t_upc'(24);
    localparam t_upc L_EN_DONE = t_upc'(27);
    localparam t_upc L_F_OP    = t_upc'(28);
    localparam t_upc L_F_PAR   = t_upc'(29);
    localparam t_upc L_F_DEL   = t_upc'(30);
    localparam t_upc L_F_OVF   = t_upc'(31);
    localparam t_upc L_FIN     = t_upc'(32);
    localparam int   UCODE_LEN = 33;

    function automatic logic f_level(input logic [OP_W-1:0] op);
        return op > OP_SUB;
    endfunction

    function automatic t_uword uw(input t_emit e, input t_stk s, input t_held h,
                                  input t_cond c, input t_upc t,
                                  input logic [ERR_W-1:0] err, input logic ls,
                                  input logic fin);
        t_uword w;
        w.emit   = e;
        w.err    = err;
        w.stk    = s;
        w.held   = h;
        w.lset   = ls;
        w.cond   = c;
        w.target = t;
        w.fin    = fin;
        return w;
    endfunction

    localparam t_uword UCODE [UCODE_LEN] = '{
        // number
        uw(E_HELD,   S_NONE,    H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_TOK,    S_NONE,    H_NONE, C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // name
        uw(E_HELD,   S_NONE,    H_SET,  C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // operator
        uw(E_HELD,   S_NONE,    H_NONE, C_BADOP,   L_F_OP,    ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_OP_STOP, L_OP_PUSH, ERR_OK, 1'b0, 1'b0),
        uw(E_TOPOP,  S_POP,     H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_LOAD,    H_NONE, C_ALWAYS,  L_OP_LOOP, ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_FULL,    L_F_OVF,   ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_PUSHOP,  H_NONE, C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // open paren
        uw(E_NONE,   S_NONE,    H_NONE, C_FULL,    L_F_OVF,   ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_PUSHPAR, H_CLR,  C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // close paren
        uw(E_HELD,   S_NONE,    H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_PSTOP,   L_CL_DONE, ERR_OK, 1'b0, 1'b0),
        uw(E_TOPOP,  S_POP,     H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_LOAD,    H_NONE, C_ALWAYS,  L_CL_LOOP, ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_EMPTY,   L_F_PAR,   ERR_OK, 1'b0, 1'b0),
        uw(E_FUNC,   S_POP,     H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_LOAD,    H_NONE, C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // delimiter
        uw(E_HELD,   S_NONE,    H_NONE, C_NO_CTX,  L_F_DEL,   ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_PSTOP,   L_DL_DONE, ERR_OK, 1'b0, 1'b0),
        uw(E_TOPOP,  S_POP,     H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_LOAD,    H_NONE, C_ALWAYS,  L_DL_LOOP, ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_INCARG,  H_NONE, C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // end
        uw(E_HELD,   S_NONE,    H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_NONE,    H_NONE, C_PSTOP,   L_EN_DONE, ERR_OK, 1'b0, 1'b0),
        uw(E_TOPOP,  S_POP,     H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b0),
        uw(E_NONE,   S_LOAD,    H_NONE, C_ALWAYS,  L_EN_LOOP, ERR_OK, 1'b0, 1'b0),
        uw(E_ENDST,  S_CLEAR,   H_NONE, C_ALWAYS,  L_FIN,     ERR_OK, 1'b0, 1'b0),
        // failures: status, drop stack and held name, latch the error
        uw(E_STATUS, S_CLEAR,   H_CLR,  C_ALWAYS,  L_FIN, ERR_BAD_OP,   1'b1, 1'b0),
        uw(E_STATUS, S_CLEAR,   H_CLR,  C_ALWAYS,  L_FIN, ERR_PARENS,   1'b1, 1'b0),
        uw(E_STATUS, S_CLEAR,   H_CLR,  C_ALWAYS,  L_FIN, ERR_DELIM,    1'b1, 1'b0),
        uw(E_STATUS, S_CLEAR,   H_CLR,  C_ALWAYS,  L_FIN, ERR_OVERFLOW, 1'b1, 1'b0),
        // finish: release the held-back result with last set
        uw(E_NONE,   S_NONE,    H_NONE, C_NEVER,   L_FIN,     ERR_OK, 1'b0, 1'b1)
    };

    function automatic t_upc f_entry(input t_kind k, input logic latched);
        t_upc pc;
        pc = L_FIN;
        if (!latched) begin
            unique case (k)
                K_NUMBER:   pc = L_NUM;
                K_NAME:     pc = L_NAME;
                K_OPERATOR: pc = L_OPR;
                K_OPEN:     pc = L_OPEN;
                K_CLOSE:    pc = L_CLOSE;
                K_DELIM:    pc = L_DELIM;
                K_SPACE:    pc = L_FIN;
                K_END:      pc = L_END;
                default:    pc = L_FIN;
            endcase
        end
        return pc;
    endfunction

endpackage

FILE: design/itp_token_if.sv
// ----------------------------------------------------------------------------
// itp_token_if: token input channel
// Valid/ready channel carrying one classified token per item.
// ----------------------------------------------------------------------------
interface itp_token_if;
    import itp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [OP_W-1:0]   op_code;
    logic [REF_W-1:0]  token_ref;

    modport source (output valid, token_kind, op_code, token_ref, input ready);
    modport sink   (input valid, token_kind, op_code, token_ref, output ready);
    modport mon    (input valid, ready, token_kind, op_code, token_ref);
endinterface

FILE: design/itp_result_if.sv
// ----------------------------------------------------------------------------
// itp_result_if: postfix result channel
// Valid/ready channel carrying one postfix result per item.
// ----------------------------------------------------------------------------
interface itp_result_if;
    import itp_pkg::*;

    logic               valid;
    logic               ready;
    logic [OKIND_W-1:0] out_kind;
    logic [REF_W-1:0]   out_ref;
    logic [OP_W-1:0]    out_op;
    logic [ARITY_W-1:0] arity;
    logic [ERR_W-1:0]   error_code;
    logic               last;

    modport source (output valid, out_kind, out_ref, out_op, arity, error_code, last,
                    input ready);
    modport sink   (input valid, out_kind, out_ref, out_op, arity, error_code, last,
                    output ready);
    modport mon    (input valid, ready, out_kind, out_ref, out_op, arity, error_code,
                    last);
endinterface

FILE: design/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram: generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/itp_useq.sv
// ----------------------------------------------------------------------------
// itp_useq: microcode sequencer
// Step counter, program fetch, dispatch on token kind and conditional jumps.
// ----------------------------------------------------------------------------
module itp_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itp_pkg::t_dpstat i_stat,
    output itp_pkg::t_ctrl   o_ctrl
);
    import itp_pkg::*;

    logic   r_busy, n_busy;
    t_upc   r_pc, n_pc;
    t_uword w;
    logic   take;

    assign w = UCODE[r_pc];

    always_comb begin
        unique case (w.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_BADOP:   take = i_stat.badop;
            C_OP_STOP: take = i_stat.op_stop;
            C_FULL:    take = i_stat.full;
            C_PSTOP:   take = i_stat.empty || i_stat.top_paren;
            C_EMPTY:   take = i_stat.empty;
            C_NO_CTX:  take = i_stat.no_ctx;
            default:   take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_stat.acc) begin
                n_busy = 1'b1;
                n_pc   = f_entry(i_stat.in_kind, i_stat.latched);
            end
        end else if (!i_stat.stall) begin
            if (w.fin) begin
                n_busy = 1'b0;
            end else if (take) begin
                n_pc = w.target;
            end else begin
                n_pc = t_upc'(r_pc + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= L_FIN;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctrl.busy = r_busy;
    assign o_ctrl.uw   = w;
endmodule

FILE: design/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath: operator stack, held name and result staging
// Executes one control word per cycle unless the output stalls; holds one result back to mark last.
// ----------------------------------------------------------------------------
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itp_token_if.sink        i_tok,
    itp_result_if.source     o_res,
    input  itp_pkg::t_ctrl   i_ctrl,
    output itp_pkg::t_dpstat o_stat
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    t_uword w;
    logic   acc, exec, stall, need_slot, ld_out, top_ne, push;

    logic [CW-1:0]    r_cnt, n_cnt, cnt_m1, cnt_m2;
    t_entry           r_top, n_top;
    logic             r_held_v, n_held_v;
    logic [REF_W-1:0] r_held_ref;
    logic             r_latched, n_latched;
    logic [OP_W-1:0]  r_tok_op;
    logic [REF_W-1:0] r_tok_ref;
    logic             r_pend_v, n_pend_v;
    t_result          r_pend, gen;
    logic             gen_v;
    logic             r_out_v, n_out_v;
    t_result          r_out;
    logic             r_out_last;
    logic [EW-1:0]    rd_data;

    assign w      = i_ctrl.uw;
    assign acc    = i_tok.valid && i_tok.ready;
    assign top_ne = r_cnt != '0;
    assign cnt_m1 = r_cnt - CW'(1);
    assign cnt_m2 = r_cnt - CW'(2);

    assign i_tok.ready = !i_ctrl.busy;

    // Result produced by this step
    always_comb begin
        gen   = '0;
        gen_v = 1'b0;
        unique case (w.emit)
            E_NONE: ;
            E_HELD: begin
                gen_v      = r_held_v;
                gen.kind   = O_OPERAND;
                gen.ref_id = r_held_ref;
            end
            E_TOK: begin
                gen_v      = 1'b1;
                gen.kind   = O_OPERAND;
                gen.ref_id = r_tok_ref;
            end
            E_TOPOP: begin
                gen_v    = 1'b1;
                gen.kind = O_OPERATOR;
                gen.op   = r_top.op;
            end
            E_FUNC: begin
                gen_v      = r_top.func;
                gen.kind   = O_CALL;
                gen.ref_id = r_top.name_ref;
                gen.arity  = r_top.argc + ARITY_W'(1);
            end
            E_STATUS: begin
                gen_v    = 1'b1;
                gen.kind = O_STATUS;
                gen.err  = w.err;
            end
            E_ENDST: begin
                gen_v    = 1'b1;
                gen.kind = O_STATUS;
                gen.err  = top_ne ? ERR_PARENS : ERR_OK;
            end
            default: ;
        endcase
    end

    // The held-back result moves out when a newer one arrives or the item ends
    assign need_slot = r_pend_v && (gen_v || w.fin);
    assign stall     = i_ctrl.busy && need_slot && r_out_v && !o_res.ready;
    assign exec      = i_ctrl.busy && !stall;
    assign ld_out    = exec && need_slot;

    always_comb begin
        n_pend_v = r_pend_v;
        if (exec && gen_v) begin
            n_pend_v = 1'b1;
        end else if (exec && w.fin) begin
            n_pend_v = 1'b0;
        end
        if (ld_out) begin
            n_out_v = 1'b1;
        end else if (o_res.ready) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    // Stack: r_top is the live top entry, memory holds the entries below it
    assign push = exec && (w.stk == S_PUSHOP || w.stk == S_PUSHPAR);

    itp_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push && top_ne),
        .i_waddr (cnt_m1[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (cnt_m2[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_cnt = r_cnt;
        n_top = r_top;
        if (exec) begin
            unique case (w.stk)
                S_NONE: ;
                S_POP: n_cnt = cnt_m1;
                S_LOAD: n_top = t_entry'(rd_data);
                S_PUSHOP: begin
                    n_top     = '0;
                    n_top.ctx = top_ne && r_top.ctx;
                    n_top.op  = r_tok_op;
                    n_cnt     = r_cnt + CW'(1);
                end
                S_PUSHPAR: begin
                    n_top          = '0;
                    n_top.paren    = 1'b1;
                    n_top.func     = r_held_v;
                    n_top.ctx      = r_held_v;
                    n_top.name_ref = r_held_ref;
                    n_cnt          = r_cnt + CW'(1);
                end
                S_CLEAR: n_cnt = '0;
                S_INCARG: begin
                    if (r_top.argc < ARG_MAX) begin
                        n_top.argc = r_top.argc + ARITY_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_held_v = r_held_v;
        if (exec) begin
            if (w.held == H_SET) begin
                n_held_v = 1'b1;
            end else if (w.held == H_CLR || w.emit == E_HELD) begin
                n_held_v = 1'b0;
            end
        end
        n_latched = r_latched;
        if (acc && r_latched && t_kind'(i_tok.token_kind) == K_END) begin
            n_latched = 1'b0;
        end else if (exec && w.lset) begin
            n_latched = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_held_v  <= 1'b0;
            r_latched <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_held_v  <= n_held_v;
            r_latched <= n_latched;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (acc) begin
            r_tok_op  <= i_tok.op_code;
            r_tok_ref <= i_tok.token_ref;
        end
        if (exec && w.held == H_SET) begin
            r_held_ref <= r_tok_ref;
        end
        if (exec && gen_v) begin
            r_pend <= gen;
        end
        if (ld_out) begin
            r_out      <= r_pend;
            r_out_last <= w.fin;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.out_kind   = r_out.kind;
    assign o_res.out_ref    = r_out.ref_id;
    assign o_res.out_op     = r_out.op;
    assign o_res.arity      = r_out.arity;
    assign o_res.error_code = r_out.err;
    assign o_res.last       = r_out_last;

    assign o_stat.acc       = acc;
    assign o_stat.in_kind   = t_kind'(i_tok.token_kind);
    assign o_stat.latched   = r_latched;
    assign o_stat.stall     = stall;
    assign o_stat.empty     = !top_ne;
    assign o_stat.full      = r_cnt == CW'(STACK_DEPTH);
    assign o_stat.top_paren = r_top.paren;
    assign o_stat.op_stop   = !top_ne || r_top.paren
                              || (!f_level(r_top.op) && f_level(r_tok_op));
    assign o_stat.no_ctx    = !top_ne || !r_top.ctx;
    assign o_stat.badop     = r_tok_op > OP_MOD;
endmodule

FILE: design/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard token reorderer
// Turns a stream of classified infix tokens into postfix results.
// ----------------------------------------------------------------------------
// One token is taken, worked off by a short microprogram, and the next token is
// accepted once its program finishes. For every operator popped off the stack,
// one step pops it and issues the read and one step reloads the new top from
// the stack memory, whose read is registered. The program stalls while the
// output register is full and not taken. Results leave through one output
// register, so the next token is accepted while the last result of the
// previous one still waits. Operands leave at once; + and - rank below *, /
// and %; all are left associative. A name directly followed by '(' becomes a
// function call that leaves after its ')' with arity = delimiters + 1
// (at most 32). Any error sends one status result, empties the stack and
// ignores tokens up to and including the next end token. An end token flushes
// the stack and sends a status result. The last flag marks the final result
// caused by each token.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itp_token_if.sink    i_tok,
    itp_result_if.source o_res
);
    import itp_pkg::*;

    // control word from the sequencer, branch flags back from the datapath
    t_ctrl   ctrl;
    t_dpstat stat;

    itp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (i_tok),
        .o_res   (o_res),
        .i_ctrl  (ctrl),
        .o_stat  (stat)
    );
endmodule

FILE: design/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker: port-level checks of the infix to postfix converter
// Watches both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module itp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_tok_valid,
    input logic                         i_tok_ready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [itp_pkg::OKIND_W-1:0]  i_res_kind,
    input logic [itp_pkg::REF_W-1:0]    i_res_ref,
    input logic [itp_pkg::OP_W-1:0]     i_res_op,
    input logic [itp_pkg::ARITY_W-1:0]  i_res_arity,
    input logic [itp_pkg::ERR_W-1:0]    i_res_err,
    input logic                         i_res_last
);
    import itp_pkg::*;

    // Output register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // A taken token closes the input in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_ready |=> !i_tok_ready)
        else $error("token accepted while previous one in progress");

    // A waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_kind)
            && $stable(i_res_ref) && $stable(i_res_op)
            && $stable(i_res_arity) && $stable(i_res_err)
            && $stable(i_res_last))
        else $error("stalled result changed");

    // A status result always closes the work of its token
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind == O_STATUS |-> i_res_last)
        else $error("status result not marked last");
endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_tok_valid (i_tok.valid),
    .i_tok_ready (i_tok.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.out_kind),
    .i_res_ref   (o_res.out_ref),
    .i_res_op    (o_res.out_op),
    .i_res_arity (o_res.arity),
    .i_res_err   (o_res.error_code),
    .i_res_last  (o_res.last)
);
